// File: hdl/dfs_topological_sort_unit_macros.svh
// Assertion helpers for the sorter.
`ifndef DFS_TOPOLOGICAL_SORT_UNIT_MACROS_SVH
`define DFS_TOPOLOGICAL_SORT_UNIT_MACROS_SVH
// Implication checked on every clock, disabled in reset.
`define DFS_ASSERT_IMP(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// Next-cycle implication.
`define DFS_ASSERT_NXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

// File: hdl/dfs_pkg.sv
package dfs_pkg;
    typedef enum logic [1:0] {
        REQ_EDGE = 2'd0,
        REQ_VERTEX = 2'd1,
        REQ_SORT = 2'd2,
        REQ_NONE = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        KIND_VERTEX = 2'd0,
        KIND_BACK = 2'd1,
        KIND_FULL = 2'd2,
        KIND_ABORT = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        COL_WHITE = 2'd0,
        COL_GRAY = 2'd1,
        COL_BLACK = 2'd2
    } t_color;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ROOT,     // pick next root vertex
        ST_SCAN,     // read edge at frame pos
        ST_EDGE,     // examine read edge
        ST_EMIT,     // output finish order in reverse
        ST_CLEAR
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;       // accept a load request
        logic sort_init;  // reset colors and counters
        logic root_step;  // advance / start root
        logic scan_rd;    // issue edge read
        logic edge_step;  // handle edge result
        logic emit_step;  // emit one vertex
        logic clear;      // clear graph
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic roots_done;
        logic root_white;
        logic stack_empty;
        logic aborted;
        logic emit_done;
    } t_sts;
endpackage

// File: hdl/dfs_topological_sort_unit.sv
// DFS topological sorter with cycle detection.
// Input: start with i_req_type/i_from_key/i_to_key, taken when busy is
// low. A full table returns one KIND_FULL item the next cycle. A sort runs
// a depth-first walk: each visited vertex scans the whole edge list,
// reading each edge in ST_SCAN and examining it in ST_EDGE, with a ST_ROOT
// step per root slot, then emits the sorted vertices in ST_EMIT and clears
// the graph in ST_CLEAR. busy stays high throughout. The edge memory read
// port, a registered read, sets the walk speed.
// Output: o_valid strobes one item per cycle; the receiver cannot stall, so
// every item is shown exactly once. o_last marks the final item of a request.
// Back edges are reported as found; in abort mode the first back edge ends
// the sort with one abort item. After a sort the graph is empty.
// Config: i_cfg_valid/o_cfg_ready write abort_on_cycle; ready is always high.
// Reset (synchronous, i_rst_n low) empties the graph and clears the mode.
// No clearing pass follows reset.
module dfs_topological_sort_unit #(
    parameter int MAX_VERTICES = 16,
    parameter int MAX_EDGES = 32,
    parameter int KEY_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          i_req_type,
    input  logic [KEY_BITS-1:0] i_from_key,
    input  logic [KEY_BITS-1:0] i_to_key,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic                i_cfg_data,
    output logic                o_valid,
    output logic [1:0]          o_kind,
    output logic [15:0]         o_first_key,
    output logic [15:0]         o_second_key,
    output logic                o_last
);
    import dfs_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;
    logic r_abort_mode;

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_abort_mode <= 1'b0;
        end else if (i_cfg_valid) begin
            r_abort_mode <= i_cfg_data;
        end
    end

    dfs_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start),
        .i_req_type(i_req_type), .i_sts(w_sts), .o_cmd(w_cmd), .o_busy(busy)
    );

    dfs_dp #(
        .MAX_VERTICES(MAX_VERTICES), .MAX_EDGES(MAX_EDGES), .KEY_BITS(KEY_BITS)
    ) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_abort_on_cycle(r_abort_mode),
        .i_req_type(i_req_type), .i_from_key(i_from_key), .i_to_key(i_to_key),
        .i_cmd(w_cmd), .o_sts(w_sts), .o_valid(o_valid), .o_kind(o_kind),
        .o_first_key(o_first_key), .o_second_key(o_second_key), .o_last(o_last)
    );
endmodule

// File: hdl/dfs_ctrl.sv
module dfs_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [1:0]    i_req_type,
    input  dfs_pkg::t_sts i_sts,
    output dfs_pkg::t_cmd o_cmd,
    output logic          o_busy
);
    import dfs_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_start && i_req_type == REQ_SORT) n_state = ST_ROOT;
            end
            ST_ROOT: begin
                if (i_sts.roots_done) n_state = ST_EMIT;
                else if (i_sts.root_white) n_state = ST_SCAN;
            end
            ST_SCAN: n_state = ST_EDGE;
            ST_EDGE: begin
                if (i_sts.aborted) n_state = ST_CLEAR;
                else if (i_sts.stack_empty) n_state = ST_ROOT;
                else n_state = ST_SCAN;
            end
            ST_EMIT: begin
                if (i_sts.emit_done) n_state = ST_CLEAR;
            end
            ST_CLEAR: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_busy = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_busy = 1'b0;
                o_cmd.load = i_start && i_req_type != REQ_SORT;
                o_cmd.sort_init = i_start && i_req_type == REQ_SORT;
            end
            ST_ROOT: o_cmd.root_step = 1'b1;
            ST_SCAN: o_cmd.scan_rd = 1'b1;
            ST_EDGE: o_cmd.edge_step = 1'b1;
            ST_EMIT: o_cmd.emit_step = 1'b1;
            ST_CLEAR: o_cmd.clear = 1'b1;
            default: o_busy = 1'b1;
        endcase
    end
endmodule

// File: hdl/dfs_dp.sv
`include "dfs_topological_sort_unit_macros.svh"
module dfs_dp #(
    parameter int MAX_VERTICES = 16,
    parameter int MAX_EDGES = 32,
    parameter int KEY_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_abort_on_cycle,
    input  logic [1:0]          i_req_type,
    input  logic [KEY_BITS-1:0] i_from_key,
    input  logic [KEY_BITS-1:0] i_to_key,
    input  dfs_pkg::t_cmd       i_cmd,
    output dfs_pkg::t_sts       o_sts,
    output logic                o_valid,
    output logic [1:0]          o_kind,
    output logic [15:0]         o_first_key,
    output logic [15:0]         o_second_key,
    output logic                o_last
);
    import dfs_pkg::*;

    localparam int VB = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int EB = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int VC = $clog2(MAX_VERTICES + 1);
    localparam int EC = $clog2(MAX_EDGES + 1);

    // vertex keys sit in flops for the parallel compare
    logic [KEY_BITS-1:0] r_keys [MAX_VERTICES];
    logic [VC-1:0]       r_vcnt;
    logic [EC-1:0]       r_ecnt;
    logic [1:0]          r_color [MAX_VERTICES];
    logic [VB-1:0]       r_stk_v [MAX_VERTICES];
    logic [EC-1:0]       r_stk_p [MAX_VERTICES];
    logic [VB-1:0]       r_fin [MAX_VERTICES];
    logic [VC-1:0]       r_sp, r_nfin, r_root;
    logic                r_abort;
    // edge memory, registered read
    logic [2*VB-1:0]     r_emem [MAX_EDGES];
    logic [2*VB-1:0]     r_erd;
    logic                r_epast;  // scanned past last edge

    logic                r_valid, r_last;
    logic [1:0]          r_kind;
    logic [15:0]         r_k1, r_k2;

    // parallel compare
    logic            a_hit, b_hit;
    logic [VB-1:0]   a_idx, b_idx;
    always_comb begin
        a_hit = 1'b0; b_hit = 1'b0; a_idx = '0; b_idx = '0;
        for (int i = 0; i < MAX_VERTICES; i++) begin
            if (VC'(i) < r_vcnt && r_keys[i] == i_from_key && !a_hit) begin
                a_hit = 1'b1; a_idx = VB'(i);
            end
            if (VC'(i) < r_vcnt && r_keys[i] == i_to_key && !b_hit) begin
                b_hit = 1'b1; b_idx = VB'(i);
            end
        end
    end

    logic          same;
    logic [1:0]    need;
    logic          e_full, v_full;
    assign same = i_from_key == i_to_key;
    assign need = {1'b0, !a_hit} + {1'b0, !b_hit && !(!a_hit && same)};
    assign e_full = ({1'b0, r_vcnt} + {{VC-1{1'b0}}, need} > (VC+1)'(MAX_VERTICES))
                    || r_ecnt >= EC'(MAX_EDGES);
    assign v_full = r_vcnt >= VC'(MAX_VERTICES);

    logic [VB-1:0] top_v, e_src, e_dst, sp_idx;
    logic [EC-1:0] top_p;
    assign sp_idx = VB'(r_sp - 1'b1);
    assign top_v = r_stk_v[sp_idx];
    assign top_p = r_stk_p[sp_idx];
    assign e_src = r_erd[2*VB-1:VB];
    assign e_dst = r_erd[VB-1:0];

    logic [VB-1:0] fin_idx;
    assign fin_idx = VB'(r_nfin - 1'b1);

    assign o_sts.roots_done  = r_root >= r_vcnt || r_abort;
    assign o_sts.root_white  = r_root < r_vcnt && r_color[VB'(r_root)] == COL_WHITE;
    assign o_sts.stack_empty = r_sp == '0 || (r_sp == VC'(1) && r_epast);
    assign o_sts.aborted     = r_abort || (!r_epast && e_src == top_v
        && r_color[e_dst] == COL_GRAY && i_abort_on_cycle);
    assign o_sts.emit_done   = r_nfin <= VC'(1) || r_abort;

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_rd) begin
            r_erd   <= r_emem[EB'(top_p)];
            r_epast <= top_p >= r_ecnt;
        end
        if (i_cmd.load && i_req_type == REQ_EDGE && !e_full)
            r_emem[EB'(r_ecnt)] <= {a_hit ? a_idx : VB'(r_vcnt),
                (b_hit ? b_idx : (same ? (a_hit ? a_idx : VB'(r_vcnt))
                                       : VB'(r_vcnt + VC'(!a_hit))))};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcnt <= '0; r_ecnt <= '0; r_valid <= 1'b0;
            r_sp <= '0; r_nfin <= '0; r_root <= '0; r_abort <= 1'b0;
            for (int i = 0; i < MAX_VERTICES; i++) r_color[i] <= COL_WHITE;
        end else begin
            r_valid <= 1'b0;
            if (i_cmd.load) begin
                if (i_req_type == REQ_EDGE) begin
                    if (e_full) begin
                        r_valid <= 1'b1; r_kind <= KIND_FULL; r_last <= 1'b1;
                        r_k1 <= '0; r_k2 <= '0;
                    end else begin
                        if (!a_hit) r_keys[VB'(r_vcnt)] <= i_from_key;
                        if (!b_hit && !same)
                            r_keys[VB'(r_vcnt + VC'(!a_hit))] <= i_to_key;
                        r_vcnt <= r_vcnt + VC'(need);
                        r_ecnt <= r_ecnt + 1'b1;
                    end
                end else if (i_req_type == REQ_VERTEX && !a_hit) begin
                    if (v_full) begin
                        r_valid <= 1'b1; r_kind <= KIND_FULL; r_last <= 1'b1;
                        r_k1 <= '0; r_k2 <= '0;
                    end else begin
                        r_keys[VB'(r_vcnt)] <= i_from_key;
                        r_vcnt <= r_vcnt + 1'b1;
                    end
                end
            end
            if (i_cmd.sort_init) begin
                r_sp <= '0; r_nfin <= '0; r_root <= '0; r_abort <= 1'b0;
                for (int i = 0; i < MAX_VERTICES; i++) r_color[i] <= COL_WHITE;
            end
            if (i_cmd.root_step && !o_sts.roots_done) begin
                r_root <= r_root + 1'b1;
                if (o_sts.root_white) begin
                    r_color[VB'(r_root)] <= COL_GRAY;
                    r_stk_v[0] <= VB'(r_root);
                    r_stk_p[0] <= '0;
                    r_sp <= VC'(1);
                end
            end
            if (i_cmd.edge_step) begin
                if (r_epast) begin
                    r_color[top_v] <= COL_BLACK;
                    r_fin[VB'(r_nfin)] <= top_v;
                    r_nfin <= r_nfin + 1'b1;
                    r_sp <= r_sp - 1'b1;
                end else if (e_src != top_v) begin
                    r_stk_p[sp_idx] <= top_p + 1'b1;
                end else begin
                    r_stk_p[sp_idx] <= top_p + 1'b1;
                    if (r_color[e_dst] == COL_WHITE) begin
                        r_color[e_dst] <= COL_GRAY;
                        r_stk_v[VB'(r_sp)] <= e_dst;
                        r_stk_p[VB'(r_sp)] <= '0;
                        r_sp <= r_sp + 1'b1;
                    end else if (r_color[e_dst] == COL_GRAY) begin
                        r_valid <= 1'b1;
                        r_k1 <= 16'(r_keys[top_v]);
                        r_k2 <= 16'(r_keys[e_dst]);
                        if (i_abort_on_cycle) begin
                            r_kind <= KIND_ABORT; r_last <= 1'b1; r_abort <= 1'b1;
                        end else begin
                            r_kind <= KIND_BACK;
                            r_last <= r_vcnt == '0;
                        end
                    end
                end
            end
            if (i_cmd.emit_step && !r_abort && r_nfin != '0) begin
                r_valid <= 1'b1; r_kind <= KIND_VERTEX;
                r_k1 <= 16'(r_keys[r_fin[fin_idx]]); r_k2 <= '0;
                r_last <= r_nfin == VC'(1);
                r_nfin <= r_nfin - 1'b1;
            end
            if (i_cmd.clear) begin
                r_vcnt <= '0; r_ecnt <= '0; r_nfin <= '0;
                for (int i = 0; i < MAX_VERTICES; i++) r_color[i] <= COL_WHITE;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_kind = r_kind;
    assign o_first_key = r_k1;
    assign o_second_key = r_k2;
    assign o_last = r_last;

    `DFS_ASSERT_IMP(a_sp_range, i_clk, i_rst_n, 1'b1, r_sp <= VC'(MAX_VERTICES))
    `DFS_ASSERT_IMP(a_fin_range, i_clk, i_rst_n, 1'b1, r_nfin <= r_vcnt || r_vcnt == '0)
    `DFS_ASSERT_NXT(a_clear, i_clk, i_rst_n, i_cmd.clear, r_vcnt == '0 && r_ecnt == '0)
endmodule

// File: sim/dfs_topological_sort_unit_tb.sv
`timescale 1ns / 100ps

module dfs_topological_sort_unit_tb;
    import dfs_pkg::*;

    localparam int NV = 16;
    localparam int NE = 32;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct {
        t_kind       kind;
        logic [15:0] first_key;
        logic [15:0] second_key;
        logic        last;
    } t_sort_item;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  i_req_type = REQ_NONE;
    logic [15:0] i_from_key = '0;
    logic [15:0] i_to_key = '0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_data = 1'b0;
    logic        o_valid;
    logic [1:0]  o_kind;
    logic [15:0] o_first_key;
    logic [15:0] o_second_key;
    logic        o_last;

    // graph mirror
    logic [15:0] g_keys [NV];
    int          g_vcount;
    int          g_esrc [NE];
    int          g_edst [NE];
    int          g_ecount;
    logic        g_abort;

    t_sort_item  pending_q [$];
    int          n_errors;
    int          n_items;
    int          cycles;
    int          burst_left;
    bit          no_gaps;

    dfs_topological_sort_unit i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_req_type   (i_req_type),
        .i_from_key   (i_from_key),
        .i_to_key     (i_to_key),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .o_valid      (o_valid),
        .o_kind       (o_kind),
        .o_first_key  (o_first_key),
        .o_second_key (o_second_key),
        .o_last       (o_last)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic report(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        n_errors++;
    endtask

    function automatic int find_vertex(input logic [15:0] key);
        for (int i = 0; i < g_vcount; i++)
            if (g_keys[i] == key) return i;
        return -1;
    endfunction

    function automatic void push_result(input t_kind k, input logic [15:0] a,
                                        input logic [15:0] b);
        t_sort_item it;
        it.kind = k;
        it.first_key = a;
        it.second_key = b;
        it.last = 1'b0;
        pending_q.push_back(it);
    endfunction

    // white/gray/black walk; slots in order, edges in load order
    function automatic void walk_and_emit();
        t_color col [NV];
        int     stk_v [NV];
        int     stk_p [NV];
        int     fin [NV];
        int     nfin, sp, v, p, w;
        bit     stopped;
        nfin = 0;
        stopped = 0;
        for (int i = 0; i < NV; i++) col[i] = COL_WHITE;
        for (int s = 0; s < g_vcount && !stopped; s++) begin
            if (col[s] != COL_WHITE) continue;
            col[s] = COL_GRAY;
            stk_v[0] = s;
            stk_p[0] = 0;
            sp = 1;
            while (sp > 0 && !stopped) begin
                v = stk_v[sp-1];
                p = stk_p[sp-1];
                while (p < g_ecount && g_esrc[p] != v) p++;
                if (p >= g_ecount) begin
                    col[v] = COL_BLACK;
                    fin[nfin++] = v;
                    sp--;
                end else begin
                    stk_p[sp-1] = p + 1;
                    w = g_edst[p];
                    if (col[w] == COL_WHITE) begin
                        col[w] = COL_GRAY;
                        stk_v[sp] = w;
                        stk_p[sp] = 0;
                        sp++;
                    end else if (col[w] == COL_GRAY) begin
                        if (g_abort) begin
                            push_result(KIND_ABORT, g_keys[v], g_keys[w]);
                            stopped = 1;
                        end else begin
                            push_result(KIND_BACK, g_keys[v], g_keys[w]);
                        end
                    end
                end
            end
        end
        if (!stopped)
            for (int i = nfin; i > 0; i--) push_result(KIND_VERTEX, g_keys[fin[i-1]], '0);
        g_vcount = 0;
        g_ecount = 0;
    endfunction

    // expected results of one accepted item
    function automatic void predict_request(input t_req req, input logic [15:0] a,
                                            input logic [15:0] b);
        int ia, ib, need, q_size0;
        q_size0 = pending_q.size();
        ia = find_vertex(a);
        ib = find_vertex(b);
        case (req)
            REQ_EDGE: begin
                need = (ia < 0) + ((ib < 0 && !(ia < 0 && a == b)) ? 1 : 0);
                if (g_vcount + need > NV || g_ecount >= NE) begin
                    push_result(KIND_FULL, '0, '0);
                end else begin
                    if (ia < 0) begin
                        g_keys[g_vcount] = a;
                        ia = g_vcount++;
                    end
                    if (ib < 0) begin
                        if (a == b) ib = ia;
                        else begin
                            g_keys[g_vcount] = b;
                            ib = g_vcount++;
                        end
                    end
                    g_esrc[g_ecount] = ia;
                    g_edst[g_ecount] = ib;
                    g_ecount++;
                end
            end
            REQ_VERTEX: begin
                if (ia < 0) begin
                    if (g_vcount >= NV) push_result(KIND_FULL, '0, '0);
                    else g_keys[g_vcount++] = a;
                end
            end
            REQ_SORT: walk_and_emit();
            default: ;
        endcase
        if (pending_q.size() > q_size0) pending_q[$].last = 1'b1;
    endfunction

    // result checker: the block strobes each result once
    always @(posedge i_clk) begin
        t_sort_item exp_it;
        if (i_rst_n && o_valid) begin
            if (pending_q.size() == 0) begin
                report($sformatf("unexpected item kind=%0d %h %h", o_kind, o_first_key,
                                 o_second_key));
            end else begin
                exp_it = pending_q.pop_front();
                if (o_kind !== exp_it.kind)
                    report($sformatf("kind %0d, want %0d", o_kind, exp_it.kind));
                if (o_first_key !== exp_it.first_key)
                    report($sformatf("first_key %h, want %h", o_first_key,
                                     exp_it.first_key));
                if (o_second_key !== exp_it.second_key)
                    report($sformatf("second_key %h, want %h", o_second_key,
                                     exp_it.second_key));
                if (o_last !== exp_it.last)
                    report($sformatf("last %b, want %b", o_last, exp_it.last));
            end
        end
    end

    // one item; start stays high across back-to-back items
    task automatic send_request(input t_req req, input logic [15:0] a, input logic [15:0] b);
        int gap;
        start <= 1'b1;
        i_req_type <= req;
        i_from_key <= a;
        i_to_key <= b;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        predict_request(req, a, b);
        n_items++;
        if (!no_gaps) begin
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                burst_left = $urandom_range(0, 10);
                gap = $urandom_range(1, 7);
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_q.size() != 0 || busy) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_abort_mode(input logic mode);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= mode;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        g_abort = mode;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic test_extreme_keys();
        set_abort_mode(1'b0);
        send_request(REQ_SORT, 16'h0000, 16'h0000);       // empty graph
        send_request(REQ_EDGE, 16'h0000, 16'hffff);
        send_request(REQ_EDGE, 16'hffff, 16'h0000);       // two-vertex cycle
        send_request(REQ_EDGE, 16'h5a5a, 16'h5a5a);       // self loop
        send_request(REQ_EDGE, 16'h0000, 16'hffff);       // duplicate edge
        send_request(REQ_VERTEX, 16'hffff, 16'h1234);     // already present
        send_request(REQ_VERTEX, 16'ha5a5, 16'hffff);
        send_request(REQ_NONE, 16'hffff, 16'hffff);       // unused code
        send_request(REQ_SORT, 16'hffff, 16'hffff);
    endtask

    task automatic test_abort_mode();
        set_abort_mode(1'b1);
        send_request(REQ_EDGE, 16'h0001, 16'h0002);
        send_request(REQ_EDGE, 16'h0002, 16'h0003);
        send_request(REQ_EDGE, 16'h0003, 16'h0001);
        send_request(REQ_EDGE, 16'h0003, 16'h0004);
        send_request(REQ_SORT, 16'h0000, 16'h0000);
        send_request(REQ_VERTEX, 16'h0007, 16'h0000);     // graph must be empty now
        send_request(REQ_SORT, 16'h0000, 16'h0000);
    endtask

    task automatic test_full_tables();
        set_abort_mode(1'b0);
        for (int i = 0; i < NV; i++) send_request(REQ_VERTEX, 16'(i * 4099), 16'h0);
        send_request(REQ_VERTEX, 16'hbeef, 16'h0);          // no slot left
        send_request(REQ_EDGE, 16'h0000, 16'hbeef);         // new key, no slot
        for (int i = 0; i < NE; i++)
            send_request(REQ_EDGE, 16'((i % NV) * 4099), 16'(((i * 7) % NV) * 4099));
        send_request(REQ_EDGE, 16'h0000, 16'h0000);         // edge store full
        send_request(REQ_SORT, 16'h0, 16'h0);
    endtask

    task automatic test_random_graphs();
        logic [15:0] pool [$];
        int          n_loads, r;
        logic [15:0] a, b;
        while (n_items < 370) begin
            if ($urandom_range(0, 3) == 0) set_abort_mode(1'($urandom));
            no_gaps = ($urandom_range(0, 4) == 0);
            pool.delete();
            r = $urandom_range(2, 20);
            for (int i = 0; i < r; i++) begin
                case ($urandom_range(0, 5))
                    0: pool.push_back(16'h0000);
                    1: pool.push_back(16'hffff);
                    default: pool.push_back(16'($urandom));
                endcase
            end
            n_loads = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 40)
                                                  : $urandom_range(1, 18);
            for (int i = 0; i < n_loads; i++) begin
                a = pool[$urandom_range(0, pool.size() - 1)];
                b = pool[$urandom_range(0, pool.size() - 1)];
                r = $urandom_range(0, 19);
                if (r < 15) send_request(REQ_EDGE, a, b);
                else if (r < 18) send_request(REQ_VERTEX, a, 16'($urandom));
                else if (r < 19) send_request(REQ_NONE, 16'($urandom), 16'($urandom));
                else send_request(REQ_EDGE, 16'($urandom), 16'($urandom));
            end
            send_request(REQ_SORT, 16'($urandom), 16'($urandom));
        end
        no_gaps = 0;
    endtask

    initial begin
        n_errors = 0;
        n_items = 0;
        cycles = 0;
        burst_left = 0;
        no_gaps = 0;
        g_vcount = 0;
        g_ecount = 0;
        g_abort = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_extreme_keys();
        test_abort_mode();
        test_full_tables();
        test_random_graphs();
        wait_idle();
        repeat (20) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

// File: files.f
+incdir+hdl
hdl/dfs_pkg.sv
hdl/dfs_ctrl.sv
hdl/dfs_dp.sv
hdl/dfs_topological_sort_unit.sv
sim/dfs_topological_sort_unit_tb.sv
